FILE: src/mrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types, widths and the modular add helper for the Miller-Rabin round block.
// ----------------------------------------------------------------------------
package mrr_pkg;

    localparam int NUMBER_BITS = 32;
    localparam int CAND_BITS   = 32;
    localparam int RAND_BITS   = 31;
    localparam int WIT_BITS    = 32;
    localparam int IDX_BITS    = $clog2(NUMBER_BITS);
    localparam int RCNT_BITS   = $clog2(RAND_BITS + 1);

    typedef enum logic [1:0] {
        VERDICT_TRIVIAL   = 2'd0,
        VERDICT_COMPOSITE = 2'd1,
        VERDICT_PASS      = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_POW_SQ,
        S_POW_MUL,
        S_CHECK,
        S_SQR,
        S_FINISH
    } mrr_state_t;

    typedef struct packed {
        logic [CAND_BITS-1:0] candidate;
        logic [RAND_BITS-1:0] random_value;
    } mrr_in_t;

    typedef struct packed {
        verdict_t             verdict;
        logic [WIT_BITS-1:0]  witness_used;
    } mrr_out_t;

    // (x + y) mod n for x, y < n
    function automatic logic [NUMBER_BITS-1:0] add_mod(
        input logic [NUMBER_BITS-1:0] x,
        input logic [NUMBER_BITS-1:0] y,
        input logic [NUMBER_BITS-1:0] n
    );
        logic [NUMBER_BITS:0] sum;
        logic [NUMBER_BITS:0] nx;
        sum = {1'b0, x} + {1'b0, y};
        nx  = {1'b0, n};
        if (sum >= nx)
        begin
            sum = sum - nx;
        end
        return sum[NUMBER_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/mrr_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, LSB first,
// stops as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module mrr_mulmod
    import mrr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [NUMBER_BITS-1:0] op_a,
    input  wire logic [NUMBER_BITS-1:0] op_b,
    input  wire logic [NUMBER_BITS-1:0] modulus,
    output logic                        done,
    output logic [NUMBER_BITS-1:0]      product
);

    logic                   busy_reg, busy_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic [NUMBER_BITS-1:0] addend_reg, addend_next;
    logic [NUMBER_BITS-1:0] mult_reg, mult_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mult_reg   <= mult_next;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mult_next   = mult_reg;
        done        = busy_reg && (mult_reg == '0);
        product     = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            acc_next    = '0;
            addend_next = op_a;
            mult_next   = op_b;
        end
        else if (busy_reg)
        begin
            if (mult_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (mult_reg[0])
                begin
                    acc_next = add_mod(acc_reg, addend_reg, modulus);
                end
                addend_next = add_mod(addend_reg, addend_reg, modulus);
                mult_next   = mult_reg >> 1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/miller_rabin_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_round - one Miller-Rabin round per item
// rejected candidates go straight from idle to the finish state; others first reduce
// the witness bit-serially, then run serial mod-mults for the power and the squarings
// throughput: one item at a time; a new item is taken only once the block is back in idle
// reset: rst_n async low, returns to idle with no result pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_round
    import mrr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire       mrr_in_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output mrr_out_t  out_item
);

    mrr_state_t             state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    mrr_out_t               out_item_reg, out_item_next;

    logic [NUMBER_BITS-1:0] n_reg, n_next;
    logic [NUMBER_BITS-1:0] nm1_reg, nm1_next;
    logic [NUMBER_BITS-1:0] d_reg, d_next;
    logic [RAND_BITS-1:0]   r_reg, r_next;
    logic [NUMBER_BITS-1:0] rem_reg, rem_next;
    logic [RCNT_BITS-1:0]   rcnt_reg, rcnt_next;
    logic [NUMBER_BITS-1:0] a_reg, a_next;
    logic [NUMBER_BITS-1:0] x_reg, x_next;
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    verdict_t               verdict_reg, verdict_next;

    logic                   mm_start;
    logic [NUMBER_BITS-1:0] mm_a;
    logic [NUMBER_BITS-1:0] mm_b;
    logic                   mm_done;
    logic [NUMBER_BITS-1:0] mm_product;

    logic [NUMBER_BITS-1:0] n_in;
    logic                   trivial;
    logic [NUMBER_BITS:0]   rem_sh;
    logic [NUMBER_BITS:0]   nm1_ext;

    mrr_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (n_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        n_reg        <= n_next;
        nm1_reg      <= nm1_next;
        d_reg        <= d_next;
        r_reg        <= r_next;
        rem_reg      <= rem_next;
        rcnt_reg     <= rcnt_next;
        a_reg        <= a_next;
        x_reg        <= x_next;
        idx_reg      <= idx_next;
        verdict_reg  <= verdict_next;
    end

    assign n_in    = NUMBER_BITS'(in_item.candidate);
    assign trivial = (n_in < NUMBER_BITS'(2)) || (!n_in[0] && (n_in != NUMBER_BITS'(2)));
    // restoring step of random_value mod (n-1), one bit per cycle
    assign rem_sh  = {rem_reg, r_reg[RAND_BITS-1]};
    assign nm1_ext = {1'b0, nm1_reg};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        n_next         = n_reg;
        nm1_next       = nm1_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        rcnt_next      = rcnt_reg;
        a_next         = a_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        verdict_next   = verdict_reg;
        mm_start       = 1'b0;
        mm_a           = mm_product;
        mm_b           = mm_product;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    n_next    = n_in;
                    nm1_next  = n_in - NUMBER_BITS'(1);
                    d_next    = n_in - NUMBER_BITS'(1);
                    r_next    = in_item.random_value;
                    rem_next  = '0;
                    rcnt_next = RCNT_BITS'(RAND_BITS);
                    if (trivial)
                    begin
                        verdict_next = VERDICT_TRIVIAL;
                        a_next       = '0;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end

            S_PREP:
            begin
                // witness reduction and stripping of twos run side by side
                if (rcnt_reg != '0)
                begin
                    if (rem_sh >= nm1_ext)
                    begin
                        rem_next = NUMBER_BITS'(rem_sh - nm1_ext);
                    end
                    else
                    begin
                        rem_next = NUMBER_BITS'(rem_sh);
                    end
                    r_next    = r_reg << 1;
                    rcnt_next = rcnt_reg - RCNT_BITS'(1);
                end
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                end
                if ((rcnt_reg == '0) && d_reg[0])
                begin
                    a_next     = rem_reg + NUMBER_BITS'(1);
                    x_next     = NUMBER_BITS'(1);
                    idx_next   = IDX_BITS'(NUMBER_BITS - 1);
                    mm_start   = 1'b1;
                    mm_a       = NUMBER_BITS'(1);
                    mm_b       = NUMBER_BITS'(1);
                    state_next = S_POW_SQ;
                end
            end

            S_POW_SQ:
            begin
                if (mm_done)
                begin
                    x_next = mm_product;
                    priority if (d_reg[idx_reg])
                    begin
                        mm_start   = 1'b1;
                        mm_b       = a_reg;
                        state_next = S_POW_MUL;
                    end
                    else if (idx_reg == '0)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_BITS'(1);
                        mm_start = 1'b1;
                    end
                end
            end

            S_POW_MUL:
            begin
                if (mm_done)
                begin
                    x_next = mm_product;
                    if (idx_reg == '0)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_BITS'(1);
                        mm_start   = 1'b1;
                        state_next = S_POW_SQ;
                    end
                end
            end

            S_CHECK:
            begin
                // d_reg now holds the running exponent
                if ((d_reg == nm1_reg) || (x_reg == NUMBER_BITS'(1)) || (x_reg == nm1_reg))
                begin
                    if ((x_reg != nm1_reg) && !d_reg[0])
                    begin
                        verdict_next = VERDICT_COMPOSITE;
                    end
                    else
                    begin
                        verdict_next = VERDICT_PASS;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = x_reg;
                    mm_b       = x_reg;
                    state_next = S_SQR;
                end
            end

            S_SQR:
            begin
                if (mm_done)
                begin
                    x_next     = mm_product;
                    d_next     = d_reg << 1;
                    state_next = S_CHECK;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.verdict      = verdict_reg;
                    out_item_next.witness_used = WIT_BITS'(a_reg);
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("block still ready after taking an item");

    a_trivial_witness: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.verdict == VERDICT_TRIVIAL) == (out_item.witness_used == '0))
    ) else $error("witness does not match verdict");

    a_mulmod_done_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == S_POW_SQ || state_reg == S_POW_MUL || state_reg == S_SQR)
    ) else $error("mod-mult finished outside a multiply state");

    a_residue_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (x_reg < n_reg)
    ) else $error("residue not reduced below candidate");

endmodule
`default_nettype wire
